[sv/cbrf_pkg.sv]
`timescale 1ns / 1ps

package cbrf_pkg;

  localparam int FRAC_BITS = 24;
  localparam int MAX_ITER  = 40;

  localparam int DATA_W  = 32;
  localparam int TOL_W   = 31;
  localparam int ITER_W  = 7;
  localparam int CNT_W   = 6;
  localparam int SQ_W    = 2 * DATA_W;
  localparam int ACC_W   = 3 * DATA_W;
  localparam int SUM_W   = ACC_W + 1;
  localparam int LIN_SH  = 2 * FRAC_BITS + 1;
  localparam int CON_SH  = 3 * FRAC_BITS;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(168);

  localparam logic [1:0] ST_CONV  = 2'd0;
  localparam logic [1:0] ST_EXACT = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_LIMIT = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] low_end;
    logic signed [DATA_W-1:0] high_end;
  } cbrf_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] root;
    logic [1:0]               status;
    logic [CNT_W-1:0]         iterations;
  } cbrf_out_t;

  typedef struct packed {
    logic zero;
    logic neg;
  } cbrf_sgn_t;

endpackage

[sv/cbrf_cubic.sv]
`timescale 1ns / 1ps

module cbrf_cubic (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [cbrf_pkg::DATA_W-1:0] value,
  output logic                          done,
  output cbrf_pkg::cbrf_sgn_t           result
);
  import cbrf_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_SQ   = 3'd1;
  localparam logic [2:0] PH_LO   = 3'd2;
  localparam logic [2:0] PH_HI   = 3'd3;
  localparam logic [2:0] PH_ACC  = 3'd4;
  localparam logic [2:0] PH_SUM  = 3'd5;

  logic [2:0]        phase_r, phase_nxt;
  logic              done_r, done_nxt;
  logic              neg_r, neg_nxt;
  logic [DATA_W-1:0] mag_r, mag_nxt;
  logic [SQ_W-1:0]   prod_r, prod_nxt;
  logic [DATA_W-1:0] sq_hi_r, sq_hi_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  cbrf_sgn_t         res_r, res_nxt;

  logic [DATA_W-1:0] mul_a;
  logic [SQ_W-1:0]   mul_p;
  logic [SUM_W-1:0]  cube_s;
  logic [SUM_W-1:0]  lin;
  logic [SUM_W-1:0]  con;
  logic [SUM_W-1:0]  sum;

  always_comb begin
    case (phase_r)
      PH_SQ:   mul_a = mag_r;
      PH_LO:   mul_a = prod_r[DATA_W-1:0];
      PH_HI:   mul_a = sq_hi_r;
      default: mul_a = mag_r;
    endcase
  end

  assign mul_p = SQ_W'(mul_a) * SQ_W'(mag_r);

  assign cube_s = neg_r ? (~SUM_W'(acc_r) + SUM_W'(1)) : SUM_W'(acc_r);
  assign lin    = SUM_W'(mag_r) << LIN_SH;
  assign con    = SUM_W'(5) << CON_SH;
  assign sum    = cube_s + (neg_r ? lin : (~lin + SUM_W'(1))) - con;

  always_comb begin
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    prod_nxt  = prod_r;
    sq_hi_nxt = sq_hi_r;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    case (phase_r)
      PH_IDLE: begin
        if (start) begin
          neg_nxt   = value[DATA_W-1];
          mag_nxt   = value[DATA_W-1] ? (~value + DATA_W'(1)) : value;
          phase_nxt = PH_SQ;
        end
      end
      PH_SQ: begin
        prod_nxt  = mul_p;
        phase_nxt = PH_LO;
      end
      PH_LO: begin
        sq_hi_nxt = prod_r[SQ_W-1:DATA_W];
        prod_nxt  = mul_p;
        phase_nxt = PH_HI;
      end
      PH_HI: begin
        acc_nxt   = ACC_W'(prod_r);
        prod_nxt  = mul_p;
        phase_nxt = PH_ACC;
      end
      PH_ACC: begin
        acc_nxt   = acc_r + (ACC_W'(prod_r) << DATA_W);
        phase_nxt = PH_SUM;
      end
      PH_SUM: begin
        res_nxt.zero = (sum == '0);
        res_nxt.neg  = sum[SUM_W-1];
        done_nxt     = 1'b1;
        phase_nxt    = PH_IDLE;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
    neg_r   <= neg_nxt;
    mag_r   <= mag_nxt;
    prod_r  <= prod_nxt;
    sq_hi_r <= sq_hi_nxt;
    acc_r   <= acc_nxt;
    res_r   <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

[sv/cubic_bisection_root_finder.sv]
`timescale 1ns / 1ps
// Each word takes the end evaluations, then one cubic evaluation per halving step,
// up to 40 steps, and then a registered output. One word is taken at a time; each cubic
// evaluation runs on one shared 32x32 multiplier. Input stalls from acceptance until the
// result is registered.
// Reset (rst_n, synchronous): sequencer idle, output empty, tolerance back to 168.
module cubic_bisection_root_finder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  cbrf_pkg::cbrf_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output cbrf_pkg::cbrf_out_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cbrf_pkg::TOL_W-1:0]  cfg_data
);
  import cbrf_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVA   = 3'd1;
  localparam logic [2:0] S_EVB   = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_EVM   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]               state_r, state_nxt;
  logic [TOL_W-1:0]         tol_r;
  logic signed [DATA_W-1:0] a_r, a_nxt;
  logic signed [DATA_W-1:0] b_r, b_nxt;
  logic signed [DATA_W-1:0] root_r, root_nxt;
  logic [1:0]               status_r, status_nxt;
  logic [ITER_W-1:0]        iters_r, iters_nxt;
  logic                     sa_neg_r, sa_neg_nxt;
  logic                     start_r, start_nxt;
  logic signed [DATA_W-1:0] opnd_r, opnd_nxt;
  logic                     out_valid_r, out_valid_nxt;
  cbrf_out_t                out_r, out_nxt;

  logic                     ev_done;
  cbrf_sgn_t                ev_res;
  logic signed [DATA_W:0]   diff;
  logic signed [DATA_W:0]   pair_sum;
  logic signed [DATA_W:0]   mid;
  logic [CNT_W-1:0]         iters_sat;

  cbrf_cubic u_cubic (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start_r),
    .value  (opnd_r),
    .done   (ev_done),
    .result (ev_res)
  );

  assign diff      = {b_r[DATA_W-1], b_r} - {a_r[DATA_W-1], a_r};
  assign pair_sum  = {b_r[DATA_W-1], b_r} + {a_r[DATA_W-1], a_r};
  assign mid       = pair_sum >>> 1;
  assign iters_sat = (iters_r > ITER_W'(63)) ? CNT_W'(63) : iters_r[CNT_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    root_nxt      = root_r;
    status_nxt    = status_r;
    iters_nxt     = iters_r;
    sa_neg_nxt    = sa_neg_r;
    start_nxt     = 1'b0;
    opnd_nxt      = opnd_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          a_nxt      = in_data.low_end;
          b_nxt      = in_data.high_end;
          root_nxt   = in_data.low_end;
          status_nxt = ST_CONV;
          iters_nxt  = '0;
          opnd_nxt   = in_data.low_end;
          start_nxt  = 1'b1;
          state_nxt  = S_EVA;
        end
      end
      S_EVA: begin
        if (ev_done) begin
          sa_neg_nxt = ev_res.neg;
          opnd_nxt   = b_r;
          start_nxt  = !ev_res.zero;
          state_nxt  = ev_res.zero ? S_OUT : S_EVB;
          if (ev_res.zero) begin
            root_nxt   = '0;
            status_nxt = ST_BAD;
          end
        end
      end
      S_EVB: begin
        if (ev_done) begin
          if (ev_res.zero || (ev_res.neg == sa_neg_r)) begin
            root_nxt   = '0;
            status_nxt = ST_BAD;
            state_nxt  = S_OUT;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (diff >= $signed({2'b00, tol_r})) begin
          if (iters_r >= ITER_W'(MAX_ITER)) begin
            status_nxt = ST_LIMIT;
            state_nxt  = S_OUT;
          end else begin
            root_nxt  = mid[DATA_W-1:0];
            opnd_nxt  = mid[DATA_W-1:0];
            iters_nxt = iters_r + ITER_W'(1);
            start_nxt = 1'b1;
            state_nxt = S_EVM;
          end
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_EVM: begin
        if (ev_done) begin
          if (ev_res.zero) begin
            status_nxt = ST_EXACT;
            state_nxt  = S_OUT;
          end else begin
            if (ev_res.neg != sa_neg_r) begin
              b_nxt = root_r;
            end else begin
              a_nxt = root_r;
            end
            state_nxt = S_CHECK;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.root       = root_r;
          out_nxt.status     = status_r;
          out_nxt.iterations = iters_sat;
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      tol_r       <= TOL_RESET;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        tol_r <= cfg_data;
      end
    end
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    root_r   <= root_nxt;
    status_r <= status_nxt;
    iters_r  <= iters_nxt;
    sa_neg_r <= sa_neg_nxt;
    opnd_r   <= opnd_nxt;
    out_r    <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

endmodule

[tb/cbrf_checker.sv]
`timescale 1ns / 1ps

module cbrf_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  cbrf_pkg::cbrf_in_t          in_data,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  cbrf_pkg::cbrf_out_t         out_data,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [cbrf_pkg::TOL_W-1:0]  cfg_data,
  output int                          fails,
  output int                          pending,
  output int                          checked,
  output int                          bad_count,
  output int                          limit_count
);
  import cbrf_pkg::*;

  logic [TOL_W-1:0] tolerance;
  cbrf_out_t        roots_due[$];
  cbrf_out_t        want;
  int               errs;

  // sign of x^3 - 2x - 5 at fixed-point x, scaled by 2^(3*FRAC_BITS)
  function automatic int cubic_sign(input longint v);
    logic signed [127:0] x;
    logic signed [127:0] f;
    x = v;
    f = x * x * x - (x <<< LIN_SH) - (128'sd5 <<< CON_SH);
    if (f == 0)
      return 0;
    return (f < 0) ? -1 : 1;
  endfunction

  function automatic cbrf_out_t bisect_root(input cbrf_in_t w, input logic [TOL_W-1:0] tol);
    longint    lo;
    longint    hi;
    longint    mid;
    longint    tol_l;
    int        s_lo;
    int        s_hi;
    int        s_mid;
    int        n;
    logic      running;
    cbrf_out_t r;
    lo     = w.low_end;
    hi     = w.high_end;
    tol_l  = tol;
    mid    = lo;
    n      = 0;
    r      = '0;
    r.status = ST_CONV;
    s_lo   = cubic_sign(lo);
    s_hi   = cubic_sign(hi);
    if (s_lo == 0 || s_hi == 0 || s_lo == s_hi) begin
      mid      = 0;
      r.status = ST_BAD;
    end else begin
      running = 1'b1;
      while (running && (hi - lo >= tol_l)) begin
        if (n >= MAX_ITER) begin
          r.status = ST_LIMIT;
          running  = 1'b0;
        end else begin
          mid   = (lo + hi) >>> 1;
          n++;
          s_mid = cubic_sign(mid);
          if (s_mid == 0) begin
            r.status = ST_EXACT;
            running  = 1'b0;
          end else if (s_mid != s_lo) begin
            hi = mid;
          end else begin
            lo = mid;
          end
        end
      end
    end
    r.root       = mid[DATA_W-1:0];
    r.iterations = (n > 63) ? CNT_W'(63) : CNT_W'(n);
    return r;
  endfunction

  always @(posedge clk) begin
    errs = 0;
    if (!rst_n) begin
      tolerance = TOL_RESET;
      roots_due.delete();
      fails       <= 0;
      pending     <= 0;
      checked     <= 0;
      bad_count   <= 0;
      limit_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (roots_due.size() == 0) begin
          $display("%0t: result with nothing expected, got root %0d status %0d iterations %0d",
                   $time, out_data.root, out_data.status, out_data.iterations);
          errs++;
        end else begin
          want = roots_due.pop_front();
          if (out_data.root !== want.root) begin
            $display("%0t: root mismatch, expected %0d got %0d",
                     $time, want.root, out_data.root);
            errs++;
          end
          if (out_data.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d got %0d",
                     $time, want.status, out_data.status);
            errs++;
          end
          if (out_data.iterations !== want.iterations) begin
            $display("%0t: iterations mismatch, expected %0d got %0d",
                     $time, want.iterations, out_data.iterations);
            errs++;
          end
          checked <= checked + 1;
          if (want.status == ST_BAD)
            bad_count <= bad_count + 1;
          if (want.status == ST_LIMIT)
            limit_count <= limit_count + 1;
        end
      end
      if (cfg_valid && cfg_ready)
        tolerance = cfg_data;
      if (in_valid && !in_stall)
        roots_due.push_back(bisect_root(in_data, tolerance));
      fails   <= fails + errs;
      pending <= roots_due.size();
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import cbrf_pkg::*;

  localparam int     WATCHDOG    = 20000;
  localparam int     PHASES      = 8;
  localparam int     PHASE_WORDS = 100;
  localparam longint ONE_Q       = longint'(1) << FRAC_BITS;
  localparam longint ROOT_Q      = 64'sd35140742;
  localparam longint Q_MIN       = -64'sd2147483648;
  localparam longint Q_MAX       = 64'sd2147483647;
  localparam logic [TOL_W-1:0] TOL_MAX = '1;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  cbrf_in_t         in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  cbrf_out_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [TOL_W-1:0] cfg_data  = '0;

  int src_idle     = 0;
  int snk_stall    = 0;
  int idle_cycles  = 0;
  int words_sent   = 0;
  int tol_settings = 1;
  int fails;
  int pending;
  int checked;
  int bad_count;
  int limit_count;

  cubic_bisection_root_finder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  cbrf_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fails       (fails),
    .pending     (pending),
    .checked     (checked),
    .bad_count   (bad_count),
    .limit_count (limit_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < snk_stall);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, WATCHDOG, pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic cbrf_in_t mk_word(input longint lo, input longint hi);
    cbrf_in_t w;
    w.low_end  = lo[DATA_W-1:0];
    w.high_end = hi[DATA_W-1:0];
    return w;
  endfunction

  // mostly brackets around the root at random widths, some reversed, some noise
  function automatic cbrf_in_t random_word();
    cbrf_in_t w;
    longint   lo;
    longint   hi;
    longint   d;
    int       pick;
    pick = $urandom_range(99);
    d    = $urandom >> $urandom_range(31);
    lo   = ROOT_Q - 1 - d;
    d    = $urandom >> $urandom_range(31);
    hi   = ROOT_Q + 1 + d;
    if (lo < Q_MIN)
      lo = Q_MIN;
    if (hi > Q_MAX)
      hi = Q_MAX;
    if (pick < 15)
      w = {$urandom, $urandom};
    else if (pick < 25)
      w = mk_word(hi, lo);
    else
      w = mk_word(lo, hi);
    return w;
  endfunction

  task automatic send_word(input cbrf_in_t w);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    words_sent++;
  endtask

  // hold off the sender until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_tolerance(input logic [TOL_W-1:0] t);
    cfg_valid <= 1'b1;
    cfg_data  <= t;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid <= 1'b0;
    tol_settings++;
  endtask

  initial begin
    logic [TOL_W-1:0] tol;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(mk_word(2 * ONE_Q, 3 * ONE_Q));
    send_word(mk_word(Q_MIN, Q_MAX));
    send_word(mk_word(3 * ONE_Q, 4 * ONE_Q));
    send_word(mk_word(Q_MIN, 0));
    send_word(mk_word(3 * ONE_Q, 2 * ONE_Q));
    send_word(mk_word(ROOT_Q - 82, ROOT_Q + 67));
    send_word(mk_word(0, Q_MAX));
    send_word(mk_word(-1, Q_MAX));
    send_word(mk_word(Q_MAX, Q_MAX));
    send_word(mk_word(Q_MIN, Q_MIN));
    send_word(mk_word(ROOT_Q, ROOT_Q + 1));
    send_word(mk_word(Q_MAX, Q_MIN));
    send_word(mk_word(-64'sd1431655766, 64'sd1431655765));
    send_word(mk_word(64'sd1431655765, -64'sd1431655766));
    drain();
    set_tolerance(TOL_W'(1));
    send_word(mk_word(2 * ONE_Q, 3 * ONE_Q));
    send_word(mk_word(Q_MIN, Q_MAX));
    send_word(mk_word(ROOT_Q, ROOT_Q + 1));
    drain();
    set_tolerance(TOL_MAX);
    send_word(mk_word(Q_MIN, Q_MAX));
    send_word(mk_word(2 * ONE_Q, 3 * ONE_Q));

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0:       tol = TOL_RESET;
        1:       tol = TOL_W'(1);
        2:       tol = TOL_MAX;
        3:       tol = TOL_W'($urandom_range(65535, 1));
        4:       tol = TOL_W'($urandom_range(32'h7FFF_FFFF, 1));
        5:       tol = TOL_W'(ONE_Q);
        6:       tol = TOL_RESET;
        default: tol = TOL_W'($urandom_range(1023, 1));
      endcase
      set_tolerance(tol);
      case (p % 4)
        0: begin
          src_idle  = 0;
          snk_stall <= 0;
        end
        1: begin
          src_idle  = 75;
          snk_stall <= 0;
        end
        2: begin
          src_idle  = 0;
          snk_stall <= 75;
        end
        default: begin
          src_idle  = 14;
          snk_stall <= 14;
        end
      endcase
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (i == PHASE_WORDS / 2)
          drain();
        send_word(random_word());
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d intervals under %0d tolerance settings; %0d roots checked,",
             words_sent, tol_settings, checked);
    $display("  %0d of them bad brackets and %0d stopped by the iteration cap",
             bad_count, limit_count);
    if (fails == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
